/* sv/dgsp_pkg.sv */
// ----------------------------------------------------------------------------
// dgsp_pkg: shared types and constants for the shortest-path block
// Vertex, weight and distance types, cell control codes and the
// controller state encoding used by the cell chain and the top level.
// ----------------------------------------------------------------------------
package dgsp_pkg;

    // Graph size: vertex count is a power of two so matrix addresses are {row, col}
    localparam int VTX_BITS     = 3;
    localparam int NUM_VERTICES = 1 << VTX_BITS;
    localparam int ADDR_BITS    = 2 * VTX_BITS;
    localparam int MAT_DEPTH    = NUM_VERTICES * NUM_VERTICES;
    localparam int WEIGHT_BITS  = 16;
    localparam int OUT_BITS     = 19;
    localparam int DIST_BITS    = OUT_BITS + 1;
    localparam int CNT_BITS     = $clog2(NUM_VERTICES + 1);

    typedef logic [VTX_BITS-1:0]    t_vtx;
    typedef logic [ADDR_BITS-1:0]   t_addr;
    typedef logic [WEIGHT_BITS-1:0] t_weight;
    typedef logic [DIST_BITS-1:0]   t_dist;
    typedef logic [OUT_BITS-1:0]    t_out_dist;
    typedef logic [CNT_BITS-1:0]    t_cnt;

    // Saturated maximum and the "unreached" mark one above it
    localparam t_dist DIST_MAX = t_dist'((1 << OUT_BITS) - 1);
    localparam t_dist DIST_INF = t_dist'(1 << OUT_BITS);

    // Command opcodes
    localparam logic OPC_LOAD = 1'b0;
    localparam logic OPC_RUN  = 1'b1;

    // Operation broadcast to every cell
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INIT,
        CELL_MARK,
        CELL_LOAD_W,
        CELL_RELAX,
        CELL_UNLOAD
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_vtx     vtx;   // source on init, picked vertex on mark
        t_dist    du;    // distance of the picked vertex
    } t_cell_ctl;

    // Min-search token passed down the chain
    typedef struct packed {
        t_dist least;
        t_vtx  pick;
    } t_token;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_PICK,
        S_FETCH,
        S_RELAX,
        S_OUTPUT
    } t_state;

endpackage

/* sv/dgsp_ram.sv */
// ----------------------------------------------------------------------------
// dgsp_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module dgsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/dgsp_cell.sv */
// ----------------------------------------------------------------------------
// dgsp_cell: one vertex of the shortest-path cell chain
// Holds the vertex's best distance and visited flag, forwards the min-search
// token and the weight stream to its neighbor, and relaxes its own distance.
// ----------------------------------------------------------------------------
module dgsp_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dgsp_pkg::t_vtx      i_idx,
    input  dgsp_pkg::t_cell_ctl i_ctl,
    input  dgsp_pkg::t_token    i_tok,
    output dgsp_pkg::t_token    o_tok,
    input  dgsp_pkg::t_weight   i_w,
    output dgsp_pkg::t_weight   o_w,
    input  dgsp_pkg::t_dist     i_dist_next,
    output dgsp_pkg::t_dist     o_dist
);
    import dgsp_pkg::*;

    t_dist   r_dist, n_dist;
    logic    r_vis, n_vis;
    t_weight r_w;
    t_token  r_tok, n_tok;

    logic [DIST_BITS:0] sum;
    t_dist              sat;

    // Candidate distance through the picked vertex, saturating
    always_comb begin
        sum = {1'b0, i_ctl.du} + (DIST_BITS + 1)'(r_w);
        sat = (sum > {1'b0, DIST_MAX}) ? DIST_MAX : sum[DIST_BITS-1:0];
    end

    // Min-search step: highest index wins ties, so take on <=
    always_comb begin
        n_tok = i_tok;
        if (!r_vis && (r_dist <= i_tok.least)) begin
            n_tok.least = r_dist;
            n_tok.pick  = i_idx;
        end
    end

    // Distance and visited updates
    always_comb begin
        n_dist = r_dist;
        n_vis  = r_vis;
        unique case (i_ctl.op)
            CELL_INIT: begin
                n_dist = (i_idx == i_ctl.vtx) ? '0 : DIST_INF;
                n_vis  = 1'b0;
            end
            CELL_MARK: begin
                if (i_idx == i_ctl.vtx) begin
                    n_vis = 1'b1;
                end
            end
            CELL_RELAX: begin
                if (!r_vis && (r_w != '0) && (sat < r_dist)) begin
                    n_dist = sat;
                end
            end
            CELL_UNLOAD: begin
                n_dist = i_dist_next;
            end
            CELL_HOLD, CELL_LOAD_W: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vis <= 1'b0;
        end else begin
            r_vis <= n_vis;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_dist <= n_dist;
        r_tok  <= n_tok;
        if (i_ctl.op == CELL_LOAD_W) begin
            r_w <= i_w;
        end
    end

    assign o_tok  = r_tok;
    assign o_w    = r_w;
    assign o_dist = r_dist;

endmodule

/* sv/dense_graph_shortest_paths.sv */
// ----------------------------------------------------------------------------
// dense_graph_shortest_paths: single-source shortest paths, adjacency matrix
// A load transaction (opcode 0) writes one edge weight; weight 0
// means no edge. A run transaction (opcode 1) computes distances from the
// source and emits one result per vertex, vertex 0 first, on consecutive
// cycles with o_strobe high; the receiver cannot stall them. busy stays high
// from the accepted run until the cycle after the last result. Each of the
// N-1 rounds of a run sweeps the min-search token down the chain of vertex
// cells, marks the pick, streams the picked row out of the matrix RAM
// through its single read port, and relaxes.
// ----------------------------------------------------------------------------
module dense_graph_shortest_paths (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_opcode,
    input  dgsp_pkg::t_vtx       i_row,
    input  dgsp_pkg::t_vtx       i_col,
    input  dgsp_pkg::t_weight    i_weight,
    input  dgsp_pkg::t_vtx       i_source_vertex,
    output logic                 o_strobe,
    output dgsp_pkg::t_vtx       o_vertex,
    output dgsp_pkg::t_out_dist  o_distance,
    output logic                 o_reached,
    output logic                 o_last
);
    import dgsp_pkg::*;

    t_state r_state, n_state;
    t_cnt   r_cnt, n_cnt;
    t_vtx   r_round, n_round;
    t_vtx   r_u, n_u;
    t_dist  r_du, n_du;
    logic   r_rd_valid;

    t_cell_ctl ctl;
    logic      wr_en;
    logic      rd_en;
    t_addr     rd_addr;
    t_weight   rd_data;

    t_token  tok_in  [NUM_VERTICES];
    t_token  tok_out [NUM_VERTICES];
    t_weight w_in    [NUM_VERTICES];
    t_weight w_out   [NUM_VERTICES];
    t_dist   d_next  [NUM_VERTICES];
    t_dist   d_out   [NUM_VERTICES];
    t_token  last_tok;

    // Edge weight matrix
    dgsp_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (MAT_DEPTH)
    ) u_mat (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr ({i_row, i_col}),
        .i_wr_data (i_weight),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Chain of vertex cells
    for (genvar k = 0; k < NUM_VERTICES; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign tok_in[k] = '{least: DIST_INF, pick: '0};
            assign w_in[k]   = rd_data;
        end else begin : g_body
            assign tok_in[k] = tok_out[k-1];
            assign w_in[k]   = w_out[k-1];
        end
        if (k == NUM_VERTICES - 1) begin : g_tail
            assign d_next[k] = DIST_INF;
        end else begin : g_inner
            assign d_next[k] = d_out[k+1];
        end

        dgsp_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_idx       (t_vtx'(k)),
            .i_ctl       (ctl),
            .i_tok       (tok_in[k]),
            .o_tok       (tok_out[k]),
            .i_w         (w_in[k]),
            .o_w         (w_out[k]),
            .i_dist_next (d_next[k]),
            .o_dist      (d_out[k])
        );
    end

    assign last_tok = tok_out[NUM_VERTICES-1];

    // Next state and sequencing counters
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_round = r_round;
        n_u     = r_u;
        n_du    = r_du;
        unique case (r_state)
            S_IDLE: begin
                if (start && (i_opcode == OPC_RUN)) begin
                    n_state = S_SEARCH;
                    n_cnt   = '0;
                    n_round = '0;
                end
            end
            S_SEARCH: begin
                if (r_cnt == t_cnt'(NUM_VERTICES - 1)) begin
                    n_state = S_PICK;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + t_cnt'(1);
                end
            end
            S_PICK: begin
                n_u     = last_tok.pick;
                n_du    = last_tok.least;
                n_state = S_FETCH;
                n_cnt   = '0;
            end
            S_FETCH: begin
                if (r_cnt == t_cnt'(NUM_VERTICES)) begin
                    n_state = S_RELAX;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + t_cnt'(1);
                end
            end
            S_RELAX: begin
                n_cnt = '0;
                if (r_round == t_vtx'(NUM_VERTICES - 2)) begin
                    n_state = S_OUTPUT;
                end else begin
                    n_state = S_SEARCH;
                    n_round = r_round + t_vtx'(1);
                end
            end
            S_OUTPUT: begin
                if (r_cnt == t_cnt'(NUM_VERTICES - 1)) begin
                    n_state = S_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + t_cnt'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Cell commands, matrix access and result strobe
    always_comb begin
        ctl      = '{op: CELL_HOLD, vtx: r_u, du: r_du};
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        // Row of the picked vertex, highest column first so it lands in the last cell
        rd_addr  = {r_u, t_vtx'(NUM_VERTICES - 1) - r_cnt[VTX_BITS-1:0]};
        o_strobe = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_opcode == OPC_RUN) begin
                        ctl.op  = CELL_INIT;
                        ctl.vtx = i_source_vertex;
                    end else begin
                        wr_en = 1'b1;
                    end
                end
            end
            S_PICK: begin
                ctl.op  = CELL_MARK;
                ctl.vtx = last_tok.pick;
            end
            S_FETCH: begin
                rd_en = (r_cnt < t_cnt'(NUM_VERTICES));
                if (r_rd_valid) begin
                    ctl.op = CELL_LOAD_W;
                end
            end
            S_RELAX: begin
                // An unreached pick relaxes nothing
                if (r_du != DIST_INF) begin
                    ctl.op = CELL_RELAX;
                end
            end
            S_OUTPUT: begin
                ctl.op   = CELL_UNLOAD;
                o_strobe = 1'b1;
            end
            S_SEARCH: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_round    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_round    <= n_round;
            r_rd_valid <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u  <= n_u;
        r_du <= n_du;
    end

    // Results stream out of the head cell
    assign busy       = (r_state != S_IDLE);
    assign o_vertex   = r_cnt[VTX_BITS-1:0];
    assign o_reached  = (d_out[0] != DIST_INF);
    assign o_distance = o_reached ? d_out[0][OUT_BITS-1:0] : DIST_MAX[OUT_BITS-1:0];
    assign o_last     = o_strobe && (r_cnt == t_cnt'(NUM_VERTICES - 1));

    // Results appear only during a run
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe outside a run");

    // The last result ends the run
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !busy)
        else $error("block still busy after last result");

    // Results come in index order without gaps
    a_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> (o_strobe && (o_vertex == $past(o_vertex) + 3'd1)))
        else $error("result sequence broken");

    // A started run makes the block busy
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == OPC_RUN)) |=> busy)
        else $error("run transaction not taken");

endmodule
